// File: src/hrhp_pkg.sv
// shared types, codes and token constants of the http request head parser
`default_nettype none

package hrhp_pkg;

    // parse phase of the current line
    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_NAME,
        PH_VALUE,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // result kind codes
    typedef enum logic [3:0] {
        KIND_IGNORED,
        KIND_METHOD,
        KIND_PATH,
        KIND_VERSION,
        KIND_HDR_NAME,
        KIND_HDR_VALUE,
        KIND_LINE_OK,
        KIND_HDR_END,
        KIND_HEAD_DONE,
        KIND_ERROR
    } t_kind;

    // method and version codes
    localparam logic [1:0] METHOD_UNKNOWN = 2'd0;
    localparam logic [1:0] METHOD_GET     = 2'd1;
    localparam logic [1:0] METHOD_POST    = 2'd2;
    localparam logic [1:0] VERSION_NONE   = 2'd0;
    localparam logic [1:0] VERSION_1_0    = 2'd1;
    localparam logic [1:0] VERSION_1_1    = 2'd2;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // token positions
    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [3:0] GET_LEN     = 4'd3;
    localparam logic [3:0] POST_LEN    = 4'd4;
    localparam logic [3:0] VERSION_LEN = 4'd8;

    // token tables, GET padded to four entries
    localparam logic [7:0] TOK_GET  [4] = '{8'h47, 8'h45, 8'h54, 8'h00};
    localparam logic [7:0] TOK_POST [4] = '{8'h50, 8'h4F, 8'h53, 8'h54};
    localparam logic [7:0] TOK_V10  [8] = '{8'h48, 8'h54, 8'h54, 8'h50,
                                            8'h2F, 8'h31, 8'h2E, 8'h30};
    localparam logic [7:0] TOK_V11  [8] = '{8'h48, 8'h54, 8'h54, 8'h50,
                                            8'h2F, 8'h31, 8'h2E, 8'h31};

    // result queue sizing
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // parser state
    typedef struct packed {
        t_phase     phase;
        logic       cr_held;
        logic [3:0] match_pos;
        logic [1:0] method_match;
        logic [1:0] version_match;
        logic [1:0] method_reg;
        logic [1:0] version_reg;
    } t_state;

    // one result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic [1:0] method_code;
        logic [1:0] version_code;
        logic       last;
    } t_result;

    // state and result after one step
    typedef struct packed {
        t_state  st;
        t_result res;
    } t_step;

    // results handed from the parser core to the queue
    typedef struct packed {
        logic       busy;
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

// File: src/hrhp_in_if.sv
// byte input channel of the http request head parser
`default_nettype none

interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: src/hrhp_out_if.sv
// result output channel of the http request head parser
`default_nettype none

interface hrhp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] out_byte;
    logic [1:0] method_code;
    logic [1:0] version_code;
    logic       last;

    modport source (output valid, output kind, output out_byte, output method_code,
                    output version_code, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input method_code,
                  input version_code, input last, output ready);
endinterface

`default_nettype wire

// File: src/hrhp_core.sv
// parser core: input byte register, parse state and per-byte result logic
`default_nettype none

module hrhp_core
    import hrhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    output t_push           o_push
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_st;
    t_state     n_st;

    t_step  w_feed_b;
    t_step  w_feed_cr;
    t_step  w_feed_cr_b;
    t_step  w_line_end;
    t_state w_mid;

    // result built from the updated state
    function automatic t_result make_res(t_state s, t_kind k, logic [7:0] b);
        t_result r;
        r.kind         = k;
        r.out_byte     = b;
        r.method_code  = s.method_reg;
        r.version_code = s.version_reg;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic [3:0] bump(logic [3:0] pos);
        return (pos < POS_MAX) ? pos + 4'd1 : pos;
    endfunction

    // one content or delimiter byte of the current line
    function automatic t_step feed(t_state s, logic [7:0] b);
        t_step      r;
        t_kind      k;
        logic [7:0] ob;
        r.st = s;
        k    = KIND_IGNORED;
        ob   = 8'd0;
        case (s.phase)
            PH_METHOD: begin
                if (b == CH_SPACE) begin
                    if (s.match_pos == GET_LEN && s.method_match[0]) begin
                        r.st.method_reg = METHOD_GET;
                    end else if (s.match_pos == POST_LEN && s.method_match[1]) begin
                        r.st.method_reg = METHOD_POST;
                    end else begin
                        r.st.method_reg = METHOD_UNKNOWN;
                    end
                    r.st.phase = PH_PATH;
                end else begin
                    if (!(s.match_pos < GET_LEN && TOK_GET[s.match_pos[1:0]] == b)) begin
                        r.st.method_match[0] = 1'b0;
                    end
                    if (!(s.match_pos < POST_LEN && TOK_POST[s.match_pos[1:0]] == b)) begin
                        r.st.method_match[1] = 1'b0;
                    end
                    r.st.match_pos = bump(s.match_pos);
                    k  = KIND_METHOD;
                    ob = b;
                end
            end
            PH_PATH: begin
                if (b == CH_SPACE) begin
                    r.st.phase         = PH_VERSION;
                    r.st.match_pos     = 4'd0;
                    r.st.version_match = 2'b11;
                end else begin
                    k  = KIND_PATH;
                    ob = b;
                end
            end
            PH_VERSION: begin
                if (!(s.match_pos < VERSION_LEN && TOK_V10[s.match_pos[2:0]] == b)) begin
                    r.st.version_match[0] = 1'b0;
                end
                if (!(s.match_pos < VERSION_LEN && TOK_V11[s.match_pos[2:0]] == b)) begin
                    r.st.version_match[1] = 1'b0;
                end
                r.st.match_pos = bump(s.match_pos);
                k  = KIND_VERSION;
                ob = b;
            end
            PH_NAME: begin
                if (b == CH_COLON) begin
                    r.st.phase = PH_VALUE;
                end else begin
                    k  = KIND_HDR_NAME;
                    ob = b;
                end
            end
            PH_VALUE: begin
                k  = KIND_HDR_VALUE;
                ob = b;
            end
            default: begin
                k = KIND_IGNORED;
            end
        endcase
        r.res = make_res(r.st, k, ob);
        return r;
    endfunction

    // cr lf line end
    function automatic t_step line_end(t_state s);
        t_step r;
        t_kind k;
        r.st = s;
        k    = KIND_IGNORED;
        case (s.phase)
            PH_VERSION: begin
                if (s.match_pos == VERSION_LEN && s.version_match[0]) begin
                    r.st.version_reg = VERSION_1_0;
                    r.st.phase       = PH_NAME;
                    k                = KIND_LINE_OK;
                end else if (s.match_pos == VERSION_LEN && s.version_match[1]) begin
                    r.st.version_reg = VERSION_1_1;
                    r.st.phase       = PH_NAME;
                    k                = KIND_LINE_OK;
                end else begin
                    r.st.phase = PH_ERROR;
                    k          = KIND_ERROR;
                end
            end
            PH_METHOD, PH_PATH: begin
                r.st.phase = PH_ERROR;
                k          = KIND_ERROR;
            end
            PH_NAME: begin
                r.st.phase = PH_DONE;
                k          = KIND_HEAD_DONE;
            end
            PH_VALUE: begin
                r.st.phase = PH_NAME;
                k          = KIND_HDR_END;
            end
            default: begin
                k = KIND_IGNORED;
            end
        endcase
        r.res = make_res(r.st, k, 8'd0);
        return r;
    endfunction

    // input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_accept;
        end
        if (i_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    // candidate steps for the registered byte
    always_comb begin
        w_feed_b         = feed(r_st, r_in_byte);
        w_feed_cr        = feed(r_st, CH_CR);
        w_mid            = w_feed_cr.st;
        w_mid.cr_held    = 1'b0;
        w_feed_cr_b      = feed(w_mid, r_in_byte);
        w_line_end       = line_end(r_st);
        w_line_end.st.cr_held = 1'b0;
    end

    // select the step and the results it produces
    always_comb begin
        n_st         = r_st;
        o_push.busy  = r_in_valid;
        o_push.count = 2'd0;
        o_push.res0  = make_res(r_st, KIND_IGNORED, 8'd0);
        o_push.res1  = make_res(r_st, KIND_IGNORED, 8'd0);
        if (r_in_valid) begin
            if (r_st.phase == PH_DONE || r_st.phase == PH_ERROR) begin
                n_st.cr_held = 1'b0;
                o_push.count = 2'd1;
            end else if (r_st.cr_held) begin
                if (r_in_byte == CH_LF) begin
                    n_st         = w_line_end.st;
                    o_push.res0  = w_line_end.res;
                    o_push.count = 2'd1;
                end else if (r_in_byte == CH_CR) begin
                    // release the held cr, hold the new one
                    n_st         = w_feed_cr.st;
                    o_push.res0  = w_feed_cr.res;
                    o_push.count = 2'd1;
                end else begin
                    n_st         = w_feed_cr_b.st;
                    o_push.res0  = w_feed_cr.res;
                    o_push.res1  = w_feed_cr_b.res;
                    o_push.count = 2'd2;
                end
            end else if (r_in_byte == CH_CR) begin
                n_st.cr_held = 1'b1;
            end else begin
                n_st         = w_feed_b.st;
                o_push.res0  = w_feed_b.res;
                o_push.count = 2'd1;
            end
        end
        // flag the final result of this byte
        if (o_push.count == 2'd2) begin
            o_push.res1.last = 1'b1;
        end else begin
            o_push.res0.last = 1'b1;
        end
    end

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= PH_METHOD;
            r_st.cr_held       <= 1'b0;
            r_st.match_pos     <= 4'd0;
            r_st.method_match  <= 2'b11;
            r_st.version_match <= 2'b11;
            r_st.method_reg    <= METHOD_UNKNOWN;
            r_st.version_reg   <= VERSION_NONE;
        end else begin
            r_st <= n_st;
        end
    end

`ifndef SYNTHESIS
    // error is sticky
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_ERROR |=> r_st.phase == PH_ERROR)
        else $error("error phase left");

    // a byte in done or error gives exactly one result
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_st.phase == PH_DONE || r_st.phase == PH_ERROR)
        |-> o_push.count == 2'd1)
        else $error("wrong result count after head end");
`endif

endmodule

`default_nettype wire

// File: src/hrhp_result_queue.sv
// result queue: takes up to two results a cycle, hands out one
`default_nettype none

module hrhp_result_queue
    import hrhp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_push              i_push,
    input  wire logic               i_pop,
    output t_result                 o_head,
    output logic [Q_CNT_W-1:0]      o_count
);

    t_result              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   w_wr_ptr1;

    assign w_wr_ptr1 = r_wr_ptr + Q_PTR_W'(1);
    assign o_head    = r_q[r_rd_ptr];
    assign o_count   = r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_q[w_wr_ptr1] <= i_push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_W'(i_push.count);
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push.count) - Q_CNT_W'(i_pop);
        end
    end

`ifndef SYNTHESIS
    // never overfilled
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // pointers agree with the fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        Q_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[Q_PTR_W-1:0])
        else $error("result queue pointers out of step");
`endif

endmodule

`default_nettype wire

// File: src/http_request_head_parser.sv
// http request head parser top level
// path: an accepted byte is registered in the core and its results enter the queue
// throughput: one byte accepted per cycle while the queue has room, results leave
// one per cycle through an eight-entry queue while the output is ready; a released cr
// makes a byte give two results, and the queue's fill level sets when the input takes the next byte
// reset: synchronous active low, parser returns to the request method phase
`default_nettype none

module http_request_head_parser
    import hrhp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hrhp_in_if.sink    i_in,
    hrhp_out_if.source o_out
);

    logic               w_accept;
    logic               w_pop;
    t_push              w_push;
    t_result            w_head;
    logic [Q_CNT_W-1:0] w_count;
    logic [Q_CNT_W:0]   w_load;

    // room for the byte in flight and a new one, two results each
    assign w_load     = {1'b0, w_count} + {{(Q_CNT_W - 1){1'b0}}, w_push.busy, 1'b0};
    assign i_in.ready = w_load <= (Q_CNT_W + 1)'(Q_DEPTH - 4);
    assign w_accept   = i_in.valid & i_in.ready;

    hrhp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .o_push      (w_push)
    );

    hrhp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // output channel
    assign o_out.valid        = w_count != '0;
    assign w_pop              = o_out.valid & o_out.ready;
    assign o_out.kind         = w_head.kind;
    assign o_out.out_byte     = w_head.out_byte;
    assign o_out.method_code  = w_head.method_code;
    assign o_out.version_code = w_head.version_code;
    assign o_out.last         = w_head.last;

`ifndef SYNTHESIS
    // the second result of a byte is already queued when the first leaves
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> o_out.valid)
        else $error("second result of a byte missing");
`endif

endmodule

`default_nettype wire
